// ===== rtl/at_command_response_engine_top_assert.svh =====
// Assertion macros for the AT command response engine top level.
// Expects signals named clock and reset in the including scope.
`ifndef AT_COMMAND_RESPONSE_ENGINE_TOP_ASSERT_SVH
`define AT_COMMAND_RESPONSE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define AT_ASSERT_IMPLY(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("at_command_response_engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define AT_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("at_command_response_engine: next-cycle check failed");

`endif

// ===== rtl/atcre_pkg.sv =====
// Shared types, codes and constants of the AT command response engine.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package atcre_pkg;

   // Default sizing
   localparam int DEF_BUF_DEPTH     = 256;
   localparam int DEF_PATTERN_BYTES = 8;

   // Fixed field widths
   localparam int TYPE_W       = 3;
   localparam int BYTE_W       = 8;
   localparam int LEN_W        = 4;
   localparam int STATUS_W     = 3;
   localparam int RSP_LEN_W    = 9;
   localparam int PAT_W        = 64;
   localparam int CFG_BYTES    = 8;
   localparam int CFG_BYTE_IDX_W = 3;
   localparam int TIMEOUT_W    = 24;
   localparam int RETRY_W      = 8;
   localparam int POLL_W       = 16;
   localparam int CSR_INDEX_W  = 3;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 24;
   localparam int QUEUE_CNT_W  = 2;
   localparam logic [QUEUE_CNT_W-1:0] QUEUE_DEPTH = 2'd2;

   // Request kinds
   localparam logic [TYPE_W-1:0] REQ_BYTE  = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_TICK  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_START = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_FLUSH = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_READ  = 3'd4;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RESEND   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DROP     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;
   localparam logic [STATUS_W-1:0] ST_READ     = 3'd5;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECT_PATTERN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECT_LENGTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_PATTERN    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_LENGTH     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_MS     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY_LIMIT    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_INTERVAL  = 3'd6;

   // Line terminator bytes
   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

   // Control from the sequencer to each window tap
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   // Compare results from each window tap
   typedef struct packed {
      logic exp_hit;
      logic end_hit;
   } cell_hit_type;

   // One response word
   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [RSP_LEN_W-1:0] resp_length;
      logic [BYTE_W-1:0]    read_byte;
   } rsp_item_type;

endpackage

// ===== rtl/atcre_window_cell.sv =====
// One byte tap of the sliding reply window, with its two byte compares.
// Depends on atcre_pkg for the control and hit structs.
`timescale 1ns / 1ps

module atcre_window_cell (
   input  logic                        clock,
   input  atcre_pkg::cell_ctrl_type    ctrl,
   input  logic [atcre_pkg::BYTE_W-1:0] byte_in,
   input  logic [atcre_pkg::BYTE_W-1:0] exp_byte,
   input  logic [atcre_pkg::BYTE_W-1:0] end_byte,
   output logic [atcre_pkg::BYTE_W-1:0] byte_out,
   output atcre_pkg::cell_hit_type     hit
);

   logic [atcre_pkg::BYTE_W-1:0] data_ff;
   logic [atcre_pkg::BYTE_W-1:0] data_in;

   // Clear wins over shift; otherwise take the neighbor's byte
   always_comb begin
      data_in = data_ff;
      if (ctrl.clear) begin
         data_in = '0;
      end else if (ctrl.shift) begin
         data_in = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Expected byte is checked on the arriving byte, end byte on the held one
   assign hit.exp_hit = (byte_in == exp_byte);
   assign hit.end_hit = (data_ff == end_byte);
   assign byte_out    = data_ff;

endmodule

// ===== rtl/atcre_rsp_queue.sv =====
// Two-word response queue between the result stage and the rsp channel.
// Depends on atcre_pkg for the response word struct.
`timescale 1ns / 1ps

module atcre_rsp_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push_valid,
   input  atcre_pkg::rsp_item_type           push_item,
   input  logic                              pop_ready,
   output logic                              out_valid,
   output atcre_pkg::rsp_item_type           out_item,
   output logic [atcre_pkg::QUEUE_CNT_W-1:0] count
);

   atcre_pkg::rsp_item_type             head_ff, head_in;
   atcre_pkg::rsp_item_type             tail_ff, tail_in;
   logic [atcre_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                                pop;

   assign pop = (count_ff != '0) && pop_ready;

   // Advance the head on pop, land the pushed word in the first free slot
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop && push_valid) begin
         if (count_ff == 2'd1) begin
            head_in = push_item;
         end else begin
            head_in = tail_ff;
            tail_in = push_item;
         end
      end else if (pop) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end else if (push_valid) begin
         if (count_ff == '0) begin
            head_in = push_item;
         end else begin
            tail_in = push_item;
         end
         count_in = count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign out_valid = (count_ff != '0);
   assign out_item  = head_ff;
   assign count     = count_ff;

endmodule

// ===== rtl/at_command_response_engine_top.sv =====
// AT command response engine: reply buffer, window taps, poll/retry sequencer.
// Depends on atcre_pkg, atcre_window_cell, atcre_rsp_queue and the assert header.
// A result word passes the result stage register and the response queue on its way to rsp.
// Throughput: one request word per cycle while req_tready is high; a two-word response queue absorbs stalls.
// Reset: synchronous; clears control state, timers and registers. The window taps
// and the reply buffer are not reset; they are compared or read only once written.
`timescale 1ns / 1ps

module at_command_response_engine_top #(
   parameter int BUF_DEPTH     = atcre_pkg::DEF_BUF_DEPTH,
   parameter int PATTERN_BYTES = atcre_pkg::DEF_PATTERN_BYTES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // req_tdata: rx_byte [7:0], line_idle [8], read_index [16:9], zero fill
   input  logic [atcre_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: req_type [2:0]
   input  logic [atcre_pkg::TYPE_W-1:0]         req_tuser,
   // Response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // rsp_tdata: resp_length [8:0], read_byte [16:9], zero fill
   output logic [atcre_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: status [2:0]
   output logic [atcre_pkg::STATUS_W-1:0]       rsp_tuser,
   // Register write port
   input  logic                                 csr_we,
   input  logic [atcre_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [atcre_pkg::PAT_W-1:0]          csr_wdata
);

   localparam int AW    = $clog2(BUF_DEPTH);
   localparam int WI_W  = AW + 1;
   localparam int LW    = atcre_pkg::LEN_W;
   localparam int BW    = atcre_pkg::BYTE_W;
   localparam int CMP_W = (WI_W > BW) ? WI_W : BW;
   localparam logic [WI_W-1:0] DEPTH_W = WI_W'(BUF_DEPTH);
   localparam logic [LW-1:0]   PAT_LEN = LW'(PATTERN_BYTES);

   // Registers
   logic [atcre_pkg::PAT_W-1:0]     expect_pat_ff;
   logic [LW-1:0]                   expect_len_ff;
   logic [atcre_pkg::PAT_W-1:0]     end_pat_ff;
   logic [LW-1:0]                   end_len_ff;
   logic [atcre_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic [atcre_pkg::RETRY_W-1:0]   retry_limit_ff;
   logic [atcre_pkg::POLL_W-1:0]    poll_interval_ff;

   // Sequencer state
   logic [WI_W-1:0]                 wi_ff, wi_in;
   logic                            seen_ff, seen_in;
   logic                            crlf_ff, crlf_in;
   logic                            newdata_ff, newdata_in;
   logic [atcre_pkg::RETRY_W-1:0]   retries_ff, retries_in;
   logic                            armed_ff, armed_in;
   logic [atcre_pkg::TIMEOUT_W-1:0] att_ff, att_in;
   logic [atcre_pkg::POLL_W-1:0]    poll_ff, poll_in;

   // Result stage
   logic                              s1_valid_ff, s1_valid_in;
   logic [atcre_pkg::STATUS_W-1:0]    s1_status_ff, s1_status_in;
   logic [atcre_pkg::RSP_LEN_W-1:0]   s1_len_ff, s1_len_in;
   logic                              s1_rdhit_ff, s1_rdhit_in;

   // Reply buffer
   logic [BW-1:0]   mem [BUF_DEPTH];
   logic [BW-1:0]   rd_ff;
   logic            mem_we;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;

   // Request fields
   logic [atcre_pkg::TYPE_W-1:0] req_type;
   logic [BW-1:0]                rx_byte;
   logic                         line_idle;
   logic [BW-1:0]                read_index;
   logic                         req_fire;

   // Window taps
   atcre_pkg::cell_ctrl_type     tap_ctrl;
   logic [BW-1:0]                tap_byte [PATTERN_BYTES];
   atcre_pkg::cell_hit_type      tap_hit  [PATTERN_BYTES];
   logic [BW-1:0]                exp_bytes [atcre_pkg::CFG_BYTES];
   logic [BW-1:0]                end_bytes [atcre_pkg::CFG_BYTES];
   logic [PATTERN_BYTES-1:0]     exp_ok;
   logic [PATTERN_BYTES-1:0]     end_ok;
   logic [LW-1:0]                el;
   logic [LW-1:0]                nl;

   // Derived values
   logic [WI_W-1:0]                 wi_inc;
   logic [atcre_pkg::POLL_W-1:0]    poll_inc;
   logic [atcre_pkg::TIMEOUT_W-1:0] att_inc;
   logic [atcre_pkg::RETRY_W-1:0]   retries_dec;
   logic                            exp_match;
   logic                            crlf_hit;
   logic                            reply_ok;
   logic                            buf_clear;

   // Response queue
   atcre_pkg::rsp_item_type             push_item;
   atcre_pkg::rsp_item_type             out_item;
   logic [atcre_pkg::QUEUE_CNT_W-1:0]   q_count;
   logic                                rsp_pop;

   // Unpack request word
   assign req_type   = req_tuser;
   assign rx_byte    = req_tdata[7:0];
   assign line_idle  = req_tdata[8];
   assign read_index = req_tdata[16:9];
   assign req_fire   = req_tvalid && req_tready;

   // Accept while the result stage is sure to find a queue slot next cycle
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign req_tready = ({1'b0, q_count} + {2'b00, s1_valid_ff}) <=
                       (3'd1 + {2'b00, rsp_pop});

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_pat_ff    <= '0;
         expect_len_ff    <= '0;
         end_pat_ff       <= '0;
         end_len_ff       <= '0;
         timeout_ff       <= '0;
         retry_limit_ff   <= '0;
         poll_interval_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            atcre_pkg::CSR_EXPECT_PATTERN: expect_pat_ff    <= csr_wdata;
            atcre_pkg::CSR_EXPECT_LENGTH:  expect_len_ff    <= csr_wdata[LW-1:0];
            atcre_pkg::CSR_END_PATTERN:    end_pat_ff       <= csr_wdata;
            atcre_pkg::CSR_END_LENGTH:     end_len_ff       <= csr_wdata[LW-1:0];
            atcre_pkg::CSR_TIMEOUT_MS:     timeout_ff       <= csr_wdata[atcre_pkg::TIMEOUT_W-1:0];
            atcre_pkg::CSR_RETRY_LIMIT:    retry_limit_ff   <= csr_wdata[atcre_pkg::RETRY_W-1:0];
            atcre_pkg::CSR_POLL_INTERVAL:  poll_interval_ff <= csr_wdata[atcre_pkg::POLL_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp pattern lengths to the window size
   assign el = (expect_len_ff > PAT_LEN) ? PAT_LEN : expect_len_ff;
   assign nl = (end_len_ff > PAT_LEN) ? PAT_LEN : end_len_ff;

   // Split patterns into bytes, first byte lowest
   genvar gk;
   generate
      for (gk = 0; gk < atcre_pkg::CFG_BYTES; gk++) begin : g_pat_bytes
         assign exp_bytes[gk] = expect_pat_ff[BW*gk +: BW];
         assign end_bytes[gk] = end_pat_ff[BW*gk +: BW];
      end
   endgenerate

   // Tap j holds the byte received j bytes ago; it compares against pattern
   // byte (length - 1 - j), and only the taps below the length take part
   genvar gi;
   generate
      for (gi = 0; gi < PATTERN_BYTES; gi++) begin : g_tap
         logic [BW-1:0]                        tap_in;
         logic [atcre_pkg::CFG_BYTE_IDX_W-1:0] exp_idx;
         logic [atcre_pkg::CFG_BYTE_IDX_W-1:0] end_idx;

         if (gi == 0) begin : g_head
            assign tap_in = rx_byte;
         end else begin : g_link
            assign tap_in = tap_byte[gi-1];
         end

         assign exp_idx = atcre_pkg::CFG_BYTE_IDX_W'(el - LW'(gi) - LW'(1));
         assign end_idx = atcre_pkg::CFG_BYTE_IDX_W'(nl - LW'(gi) - LW'(1));

         atcre_window_cell u_tap (
            .clock    (clock),
            .ctrl     (tap_ctrl),
            .byte_in  (tap_in),
            .exp_byte (exp_bytes[exp_idx]),
            .end_byte (end_bytes[end_idx]),
            .byte_out (tap_byte[gi]),
            .hit      (tap_hit[gi])
         );

         assign exp_ok[gi] = (LW'(gi) >= el) || tap_hit[gi].exp_hit;
         assign end_ok[gi] = (LW'(gi) >= nl) || tap_hit[gi].end_hit;
      end
   endgenerate

   // Window tests
   assign wi_inc    = wi_ff + WI_W'(1);
   assign exp_match = (el != '0) && (wi_inc >= WI_W'(el)) && (&exp_ok);
   assign crlf_hit  = (wi_inc >= WI_W'(2)) && (rx_byte == atcre_pkg::CHAR_LF) &&
                      (tap_byte[0] == atcre_pkg::CHAR_CR);
   assign reply_ok  = ((el == '0) || seen_ff) &&
                      ((nl == '0) || ((wi_ff > WI_W'(nl)) && (&end_ok)));

   // Saturating timers
   assign poll_inc    = (poll_ff != '1) ? (poll_ff + 1'b1) : poll_ff;
   assign att_inc     = (armed_ff && (att_ff != '1)) ? (att_ff + 1'b1) : att_ff;
   assign retries_dec = (retries_ff != '0) ? (retries_ff - 1'b1) : retries_ff;

   // Sequencer: one request word per cycle while req_tready is high
   always_comb begin
      wi_in        = wi_ff;
      seen_in      = seen_ff;
      crlf_in      = crlf_ff;
      newdata_in   = newdata_ff;
      retries_in   = retries_ff;
      armed_in     = armed_ff;
      att_in       = att_ff;
      poll_in      = poll_ff;
      s1_valid_in  = 1'b0;
      s1_status_in = atcre_pkg::ST_OK;
      s1_len_in    = '0;
      s1_rdhit_in  = 1'b0;
      buf_clear    = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      tap_ctrl     = '0;
      if (req_fire) begin
         case (req_type)
            atcre_pkg::REQ_BYTE: begin
               mem_we         = 1'b1;
               tap_ctrl.shift = 1'b1;
               newdata_in     = 1'b1;
               wi_in          = wi_inc;
               if (exp_match) begin
                  seen_in = 1'b1;
               end
               if (crlf_hit) begin
                  crlf_in = 1'b1;
               end
               if (wi_inc == DEPTH_W) begin
                  buf_clear    = 1'b1;
                  s1_valid_in  = 1'b1;
                  s1_status_in = atcre_pkg::ST_OVERFLOW;
               end
            end
            atcre_pkg::REQ_TICK: begin
               poll_in = poll_inc;
               att_in  = att_inc;
               if ((poll_inc >= poll_interval_ff) && line_idle) begin
                  poll_in = '0;
                  if ((retries_ff != '0) && newdata_ff) begin
                     newdata_in = 1'b0;
                  end
                  if ((retries_ff != '0) && newdata_ff && reply_ok) begin
                     retries_in   = '0;
                     armed_in     = 1'b0;
                     buf_clear    = 1'b1;
                     s1_valid_in  = 1'b1;
                     s1_status_in = atcre_pkg::ST_OK;
                     s1_len_in    = atcre_pkg::RSP_LEN_W'(wi_ff);
                  end else if (armed_ff && (att_inc >= timeout_ff)) begin
                     retries_in  = retries_dec;
                     s1_valid_in = 1'b1;
                     if (retries_dec == '0) begin
                        armed_in     = 1'b0;
                        buf_clear    = 1'b1;
                        s1_status_in = atcre_pkg::ST_TIMEOUT;
                     end else begin
                        att_in       = '0;
                        s1_status_in = atcre_pkg::ST_RESEND;
                     end
                  end else if ((retries_ff == '0) && (wi_ff > WI_W'(2)) && crlf_ff) begin
                     buf_clear    = 1'b1;
                     s1_valid_in  = 1'b1;
                     s1_status_in = atcre_pkg::ST_DROP;
                  end
               end
            end
            atcre_pkg::REQ_START: begin
               if (timeout_ff != '0) begin
                  retries_in = retry_limit_ff;
                  armed_in   = 1'b1;
                  att_in     = '0;
                  buf_clear  = 1'b1;
               end
            end
            atcre_pkg::REQ_FLUSH: begin
               buf_clear  = 1'b1;
               retries_in = '0;
               armed_in   = 1'b0;
            end
            atcre_pkg::REQ_READ: begin
               rd_en        = 1'b1;
               s1_rdhit_in  = (CMP_W'(read_index) < CMP_W'(wi_ff));
               s1_valid_in  = 1'b1;
               s1_status_in = atcre_pkg::ST_READ;
            end
            default: ;
         endcase
      end
      // Drop the buffered line; the new-data flag survives
      if (buf_clear) begin
         wi_in          = '0;
         seen_in        = 1'b0;
         crlf_in        = 1'b0;
         tap_ctrl.clear = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff       <= '0;
         seen_ff     <= 1'b0;
         crlf_ff     <= 1'b0;
         newdata_ff  <= 1'b0;
         retries_ff  <= '0;
         armed_ff    <= 1'b0;
         att_ff      <= '0;
         poll_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         wi_ff       <= wi_in;
         seen_ff     <= seen_in;
         crlf_ff     <= crlf_in;
         newdata_ff  <= newdata_in;
         retries_ff  <= retries_in;
         armed_ff    <= armed_in;
         att_ff      <= att_in;
         poll_ff     <= poll_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_status_ff <= s1_status_in;
      s1_len_ff    <= s1_len_in;
      s1_rdhit_ff  <= s1_rdhit_in;
   end

   // Reply buffer: write at the fill point, registered read
   assign rd_addr = AW'(read_index);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wi_ff[AW-1:0]] <= rx_byte;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // Hand the result word to the queue
   always_comb begin
      push_item.status      = s1_status_ff;
      push_item.resp_length = s1_len_ff;
      push_item.read_byte   = s1_rdhit_ff ? rd_ff : '0;
   end

   atcre_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s1_valid_ff),
      .push_item  (push_item),
      .pop_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_item   (out_item),
      .count      (q_count)
   );

   assign rsp_tuser = out_item.status;
   assign rsp_tdata = {{(atcre_pkg::RSP_DATA_W - atcre_pkg::RSP_LEN_W - BW){1'b0}},
                       out_item.read_byte, out_item.resp_length};

   // Checks
`include "at_command_response_engine_top_assert.svh"

   `AT_ASSERT_IMPLY(a_queue_room, s1_valid_ff && !rsp_pop, q_count != atcre_pkg::QUEUE_DEPTH)
   `AT_ASSERT_IMPLY(a_fill_bound, 1'b1, wi_ff < DEPTH_W)
   `AT_ASSERT_IMPLY(a_retry_armed, retries_ff != '0, armed_ff)
   `AT_ASSERT_NEXT(a_read_result, req_fire && (req_type == atcre_pkg::REQ_READ), s1_valid_ff && (s1_status_ff == atcre_pkg::ST_READ))

endmodule
